### hw/rtl/bbe_pkg.sv
// bbe_pkg: shared types, codes and character constants of the brace block end finder
// no dependencies; imported by bbe_step, brace_block_end_finder and bbe_checker

package bbe_pkg;

	localparam int unsigned MAX_DEPTH = 255;
	localparam logic [7:0] DEPTH_CAP = (MAX_DEPTH > 255) ? 8'd255 : 8'(MAX_DEPTH);

	localparam logic [7:0] CH_LBRACE    = 8'h7B;
	localparam logic [7:0] CH_RBRACE    = 8'h7D;
	localparam logic [7:0] CH_SLASH     = 8'h2F;
	localparam logic [7:0] CH_STAR      = 8'h2A;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_NEWLINE   = 8'h0A;
	localparam logic [7:0] CH_DQUOTE    = 8'h22;
	localparam logic [7:0] CH_SQUOTE    = 8'h27;

	typedef enum logic [2:0] {
		MODE_CODE       = 3'd0,
		MODE_SLASH      = 3'd1,
		MODE_STR        = 3'd2,
		MODE_STR_ESC    = 3'd3,
		MODE_LINE       = 3'd4,
		MODE_BLOCK      = 3'd5,
		MODE_BLOCK_STAR = 3'd6
	} lex_mode_t;

	localparam logic [1:0] CLS_CODE  = 2'd0;
	localparam logic [1:0] CLS_STR   = 2'd1;
	localparam logic [1:0] CLS_LINE  = 2'd2;
	localparam logic [1:0] CLS_BLOCK = 2'd3;

	localparam logic [1:0] END_NONE     = 2'd0;
	localparam logic [1:0] END_CLOSED   = 2'd1;
	localparam logic [1:0] END_UNCLOSED = 2'd2;

	localparam logic [1:0] FAULT_NONE  = 2'd0;
	localparam logic [1:0] FAULT_STRAY = 2'd1;
	localparam logic [1:0] FAULT_SAT   = 2'd2;

	typedef struct packed {
		lex_mode_t  mode;
		logic       quote_single;
		logic [7:0] depth;
	} scan_state_t;

	typedef struct packed {
		logic [1:0] end_kind;
		logic [7:0] depth;
		logic [1:0] context_res;
		logic [1:0] fault;
	} scan_result_t;

endpackage

### hw/rtl/bbe_step.sv
// bbe_step: combinational scan of one byte against the lexical state
// depends on bbe_pkg

module bbe_step import bbe_pkg::*; (
	input  logic [7:0]   ch,
	input  logic         start_req,
	input  logic         last,
	input  scan_state_t  cur,
	output scan_state_t  nxt,
	output scan_result_t res
);

	scan_state_t  st;
	logic         do_code;
	logic [1:0]   kind;
	logic [1:0]   cls;
	logic [1:0]   flt;
	logic [7:0]   quote;

	always_comb begin
		if (start_req) begin
			st = '{mode: MODE_CODE, quote_single: 1'b0, depth: 8'd0};
		end else begin
			st = cur;
		end
		kind    = END_NONE;
		flt     = FAULT_NONE;
		cls     = CLS_CODE;
		do_code = 1'b0;
		quote   = st.quote_single ? CH_SQUOTE : CH_DQUOTE;

		unique case (st.mode)
			MODE_STR: begin
				cls = CLS_STR;
				if (ch == quote) begin
					st.mode = MODE_CODE;
				end else if (ch == CH_BACKSLASH) begin
					st.mode = MODE_STR_ESC;
				end
			end
			MODE_STR_ESC: begin
				cls     = CLS_STR;
				st.mode = MODE_STR;
			end
			MODE_LINE: begin
				cls = CLS_LINE;
				if (ch == CH_NEWLINE) begin
					st.mode = MODE_CODE;
				end
			end
			MODE_BLOCK: begin
				cls = CLS_BLOCK;
				if (ch == CH_STAR) begin
					st.mode = MODE_BLOCK_STAR;
				end
			end
			MODE_BLOCK_STAR: begin
				cls = CLS_BLOCK;
				if (ch == CH_SLASH) begin
					st.mode = MODE_CODE;
				end else if (ch != CH_STAR) begin
					st.mode = MODE_BLOCK;
				end
			end
			MODE_SLASH: begin
				if (ch == CH_SLASH) begin
					st.mode = MODE_LINE;
					cls     = CLS_LINE;
				end else if (ch == CH_STAR) begin
					st.mode = MODE_BLOCK;
					cls     = CLS_BLOCK;
				end else begin
					st.mode = MODE_CODE;
					do_code = 1'b1;
				end
			end
			default: begin
				st.mode = MODE_CODE;
				do_code = 1'b1;
			end
		endcase

		// plain code byte
		if (do_code) begin
			if (ch == CH_LBRACE) begin
				if (st.depth >= DEPTH_CAP) begin
					flt = FAULT_SAT;
				end else begin
					st.depth = st.depth + 8'd1;
				end
			end else if (ch == CH_RBRACE) begin
				if (st.depth == 8'd0) begin
					flt = FAULT_STRAY;
				end else begin
					st.depth = st.depth - 8'd1;
					if (st.depth == 8'd0) begin
						kind = END_CLOSED;
					end
				end
			end else if (ch == CH_DQUOTE || ch == CH_SQUOTE) begin
				st.mode         = MODE_STR;
				st.quote_single = (ch == CH_SQUOTE);
				cls             = CLS_STR;
			end else if (ch == CH_SLASH) begin
				st.mode = MODE_SLASH;
			end
		end

		res.depth       = st.depth;
		res.context_res = cls;
		res.fault       = flt;

		// clear after an end
		if (kind == END_CLOSED || last) begin
			if (kind != END_CLOSED) begin
				kind = END_UNCLOSED;
			end
			nxt = '{mode: MODE_CODE, quote_single: 1'b0, depth: 8'd0};
		end else begin
			nxt = st;
		end
		res.end_kind = kind;
	end

endmodule

### hw/rtl/brace_block_end_finder.sv
// brace_block_end_finder: top level with input register, scan state and result register
// depends on bbe_pkg and bbe_step

// One source byte per transaction, one result per byte, in order. A byte is held in
// an input register, scanned there against the lexical state by a
// single combinational step, and its result is written to the output register
// when that step advances; out_valid is driven from that register, and a new byte is taken every
// cycle while the output side is not stalled. The result register lets the next byte
// enter while a result still waits to be taken.
module brace_block_end_finder import bbe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] ch,
	input  logic       start_req,
	input  logic       last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] end_kind,
	output logic [7:0] depth,
	output logic [1:0] context_res,
	output logic [1:0] fault
);

	logic         valid_s1;
	logic [7:0]   ch_s1;
	logic         start_s1;
	logic         last_s1;
	logic         advance;
	scan_state_t  state_q;
	scan_state_t  state_nxt;
	scan_result_t res;
	scan_result_t res_s2;
	logic         valid_s2;

	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;

	bbe_step u_step (
		.ch        (ch_s1),
		.start_req (start_s1),
		.last      (last_s1),
		.cur       (state_q),
		.nxt       (state_nxt),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= '{mode: MODE_CODE, quote_single: 1'b0, depth: 8'd0};
		end else begin
			if (in_valid && !in_stall) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
				state_q  <= state_nxt;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			ch_s1    <= ch;
			start_s1 <= start_req;
			last_s1  <= last;
		end
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_valid   = valid_s2;
	assign end_kind    = res_s2.end_kind;
	assign depth       = res_s2.depth;
	assign context_res = res_s2.context_res;
	assign fault       = res_s2.fault;

endmodule

### hw/rtl/bbe_checker.sv
// bbe_checker: port-level assertions for brace_block_end_finder, bound to the top level
// depends on bbe_pkg

module bbe_checker import bbe_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] end_kind,
	input logic [7:0] depth,
	input logic [1:0] context_res,
	input logic [1:0] fault
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// a matching close leaves depth zero, in code, without fault
	a_closed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_kind == END_CLOSED |->
		depth == 8'd0 && context_res == CLS_CODE && fault == FAULT_NONE)
		else $error("close result inconsistent");

	// an ignored stray close happens only in code at depth zero
	a_stray: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fault == FAULT_STRAY |->
		depth == 8'd0 && context_res == CLS_CODE && end_kind != END_CLOSED)
		else $error("stray close inconsistent");

	// saturation only at the cap
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fault == FAULT_SAT |-> depth == DEPTH_CAP && context_res == CLS_CODE)
		else $error("saturation below cap");

endmodule

bind brace_block_end_finder bbe_checker u_bbe_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.end_kind    (end_kind),
	.depth       (depth),
	.context_res (context_res),
	.fault       (fault)
);
